[sv/fas_pkg.sv]
`default_nettype none

package fas_pkg;

	localparam int unsigned ExpW  = 8;
	localparam int unsigned FracW = 23;
	localparam int unsigned SigW  = FracW + 1;

	localparam logic [ExpW-1:0] ExpMax   = 8'hff;
	localparam logic [31:0]     ExpMask  = 32'h7f80_0000;
	localparam logic [31:0]     QuietNan = 32'h7fc0_0000;

	// one classified operation, handed from the front to the back
	typedef struct packed {
		logic            nan;
		logic            s_big;
		logic            s_small;
		logic [ExpW-1:0] e_big;
		logic [ExpW-1:0] shamt;
		logic [SigW-1:0] m_big;
		logic [SigW-1:0] m_small;
	} fas_op_t;

	// handshake between queue and its neighbors
	typedef struct packed {
		logic push;
		logic full;
	} fas_qin_t;

	typedef struct packed {
		logic pop;
		logic empty;
	} fas_qout_t;

endpackage

`default_nettype wire

[sv/float32_add_subtract_core.sv]
// channel   | signals                           | beat taken when
// ----------+-----------------------------------+------------------------
// operation | operand_a, operand_b, mode        | start && !busy
// result    | result                            | done (one cycle)
//
// One operation per cycle sustained while busy is low; an accepted operation
// passes the front register, the queue and the three back-end stages to done.
// Front stage classifies and swaps operands, a two-entry queue follows, the back
// end aligns, adds, then normalizes and packs in three register stages.
// The back end never stalls, so busy stays low in practice; it only rises if the
// queue were ever full. arst_n clears all valid flags; no clearing pass.
`default_nettype none

module float32_add_subtract_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] operand_a,
	input  wire logic [31:0] operand_b,
	input  wire logic        mode,
	output logic             done,
	output logic [31:0]      result
);

	fas_pkg::fas_qin_t  qin;
	fas_pkg::fas_qout_t qout;
	fas_pkg::fas_op_t   front_op;
	fas_pkg::fas_op_t   back_op;
	logic               q_full;

	fas_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.mode      (mode),
		.qin       (qin),
		.q_full    (q_full),
		.op        (front_op)
	);

	fas_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.qin    (qin),
		.wr_op  (front_op),
		.full   (q_full),
		.qout   (qout),
		.rd_op  (back_op)
	);

	fas_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qout   (qout),
		.op     (back_op),
		.done   (done),
		.result (result)
	);

endmodule

`default_nettype wire

[sv/fas_front.sv]
`default_nettype none

module fas_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire logic [31:0]      operand_a,
	input  wire logic [31:0]      operand_b,
	input  wire logic             mode,
	output fas_pkg::fas_qin_t     qin,
	input  wire logic             q_full,
	output fas_pkg::fas_op_t      op
);

	logic             v_s1;
	fas_pkg::fas_op_t op_s1;
	fas_pkg::fas_op_t op_d;
	logic             accept;
	logic             adv;

	logic [fas_pkg::ExpW-1:0] ea;
	logic [fas_pkg::ExpW-1:0] eb;
	logic [fas_pkg::SigW-1:0] ma;
	logic [fas_pkg::SigW-1:0] mb;
	logic                     sa;
	logic                     sb;

	// stage register moves on when empty or when the queue takes its item
	assign adv    = !v_s1 || !q_full;
	assign busy   = !adv;
	assign accept = start && adv;

	always_comb begin
		ea = operand_a[30:23];
		eb = operand_b[30:23];
		sa = operand_a[31];
		sb = operand_b[31] ^ mode;
		// denormals count as zero
		ma = (ea != '0) ? {1'b1, operand_a[22:0]} : '0;
		mb = (eb != '0) ? {1'b1, operand_b[22:0]} : '0;
		op_d.nan = (ea == fas_pkg::ExpMax) || (eb == fas_pkg::ExpMax);
		if (ea >= eb) begin
			op_d.s_big   = sa;
			op_d.s_small = sb;
			op_d.e_big   = ea;
			op_d.shamt   = ea - eb;
			op_d.m_big   = ma;
			op_d.m_small = mb;
		end else begin
			op_d.s_big   = sb;
			op_d.s_small = sa;
			op_d.e_big   = eb;
			op_d.shamt   = eb - ea;
			op_d.m_big   = mb;
			op_d.m_small = ma;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= op_d;
		end
	end

	assign qin.push = v_s1 && !q_full;
	assign qin.full = q_full;
	assign op       = op_s1;

endmodule

`default_nettype wire

[sv/fas_queue.sv]
`default_nettype none

module fas_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire fas_pkg::fas_qin_t qin,
	input  wire fas_pkg::fas_op_t  wr_op,
	output logic                   full,
	output fas_pkg::fas_qout_t     qout,
	output fas_pkg::fas_op_t       rd_op
);

	localparam int unsigned Depth = 2;

	fas_pkg::fas_op_t mem_q [Depth];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             pop;
	logic             empty;

	assign empty = (count_q == 2'd0);
	assign full  = (count_q == 2'(Depth));
	// back end never stalls, so the head entry leaves whenever the queue is not empty
	assign pop   = !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (qin.push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(qin.push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (qin.push) begin
			mem_q[wr_ptr_q] <= wr_op;
		end
	end

	assign rd_op      = mem_q[rd_ptr_q];
	assign qout.pop   = pop;
	assign qout.empty = empty;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(qin.push && qin.full))
		else $error("queue written while full");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'(Depth))
		else $error("queue count out of range");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(qin.push && !pop) |=> (count_q == $past(count_q) + 2'd1))
		else $error("queue count lost a push");

endmodule

`default_nettype wire

[sv/fas_back.sv]
`default_nettype none

module fas_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire fas_pkg::fas_qout_t qout,
	input  wire fas_pkg::fas_op_t   op,
	output logic                    done,
	output logic [31:0]             result
);

	localparam int unsigned SigW = fas_pkg::SigW;
	localparam int unsigned ExpW = fas_pkg::ExpW;

	// align
	logic            v_s2;
	logic            nan_s2;
	logic            s_big_s2;
	logic            s_small_s2;
	logic [ExpW-1:0] e_s2;
	logic [SigW-1:0] m_big_s2;
	logic [SigW-1:0] m_sh_s2;

	// add
	logic            v_s3;
	logic            nan_s3;
	logic            sgn_s3;
	logic [ExpW-1:0] e_s3;
	logic [SigW:0]   mag_s3;

	// normalize and pack
	logic            v_s4;
	logic [31:0]     result_s4;

	logic [SigW:0]   sum;
	logic [SigW:0]   dif_bs;
	logic [SigW:0]   dif_sb;
	logic [SigW:0]   mag_d;
	logic            sgn_d;

	logic [4:0]          lz;
	logic [SigW-1:0]     norm;
	logic signed [9:0]   e_n;
	logic [31:0]         pack_d;

	function automatic logic [4:0] lzc(input logic [SigW-1:0] v);
		logic [4:0] n;
		n = 5'(SigW);
		for (int i = 0; i < SigW; i++) begin
			if (v[i]) begin
				n = 5'(SigW - 1 - i);
			end
		end
		return n;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s2 <= qout.pop;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (qout.pop) begin
			nan_s2     <= op.nan;
			s_big_s2   <= op.s_big;
			s_small_s2 <= op.s_small;
			e_s2       <= op.e_big;
			m_big_s2   <= op.m_big;
			// truncating shift; any gap of 24 or more clears it
			m_sh_s2    <= op.m_small >> op.shamt;
		end
	end

	always_comb begin
		sum    = {1'b0, m_big_s2} + {1'b0, m_sh_s2};
		dif_bs = {1'b0, m_big_s2} - {1'b0, m_sh_s2};
		dif_sb = {1'b0, m_sh_s2} - {1'b0, m_big_s2};
		priority if (s_big_s2 == s_small_s2) begin
			mag_d = sum;
			sgn_d = s_big_s2;
		end else if (!dif_bs[SigW]) begin
			mag_d = dif_bs;
			sgn_d = s_big_s2;
		end else begin
			mag_d = dif_sb;
			sgn_d = s_small_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			nan_s3 <= nan_s2;
			sgn_s3 <= sgn_d;
			e_s3   <= e_s2;
			mag_s3 <= mag_d;
		end
	end

	always_comb begin
		lz = lzc(mag_s3[SigW-1:0]);
		if (mag_s3[SigW]) begin
			norm = mag_s3[SigW:1];
			e_n  = $signed({2'b00, e_s3}) + 10'sd1;
		end else begin
			norm = mag_s3[SigW-1:0] << lz;
			e_n  = $signed({2'b00, e_s3}) - $signed({5'd0, lz});
		end
		priority if (nan_s3) begin
			pack_d = fas_pkg::QuietNan;
		end else if (mag_s3 == '0) begin
			pack_d = '0;
		end else if (e_n >= 10'sd255) begin
			pack_d = {sgn_s3, 31'd0} | fas_pkg::ExpMask;
		end else if (e_n <= 10'sd0) begin
			pack_d = {sgn_s3, 31'd0};
		end else begin
			pack_d = {sgn_s3, e_n[ExpW-1:0], norm[SigW-2:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3) begin
			result_s4 <= pack_d;
		end
	end

	assign done   = v_s4;
	assign result = result_s4;

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		qout.pop |-> !qout.empty)
		else $error("pop from an empty queue");

	a_pipe_flow: assert property (@(posedge clk) disable iff (!arst_n)
		qout.pop |=> ##2 done)
		else $error("popped operation did not reach the output");

	a_nan_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && nan_s3) |=> (result == fas_pkg::QuietNan))
		else $error("special operand did not give quiet NaN");

endmodule

`default_nettype wire

[dv/tb_top.sv]
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic OpAdd = 1'b0;
	localparam logic OpSub = 1'b1;

	localparam int NumRandom  = 1330;
	localparam int StallLimit = 1000;
	localparam int SettleCyc  = 12;
	localparam int NumRows    = 22;

	typedef struct {
		logic [31:0] a;
		logic [31:0] b;
		logic        op;
		logic        known;
		logic [31:0] want;
	} fp_row_t;

	typedef struct {
		logic [31:0] a;
		logic [31:0] b;
		logic        op;
		logic [31:0] want;
	} fp_sum_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        start     = 1'b0;
	logic [31:0] operand_a = '0;
	logic [31:0] operand_b = '0;
	logic        mode      = OpAdd;
	logic [31:0] want_now  = '0;
	logic        busy;
	logic        done;
	logic [31:0] result;

	fp_sum_t pending_sums[$];
	int      fail_cnt   = 0;
	int      ops_sent   = 0;
	int      sums_seen  = 0;
	int      nan_seen   = 0;
	int      zero_seen  = 0;
	int      inf_seen   = 0;
	int      stall_cyc  = 0;

	// known-answer rows; the others go through the predictor
	fp_row_t fp_rows [NumRows] = '{
		'{32'h0000_0000, 32'h0000_0000, OpAdd, 1'b1, 32'h0000_0000},
		'{32'h8000_0000, 32'h8000_0000, OpAdd, 1'b1, 32'h0000_0000},
		'{32'h8000_0000, 32'h0000_0000, OpSub, 1'b1, 32'h0000_0000},
		'{32'h7fc0_0000, 32'h3f80_0000, OpAdd, 1'b1, fas_pkg::QuietNan},
		'{32'h3f80_0000, 32'h7f80_0000, OpSub, 1'b1, fas_pkg::QuietNan},
		'{32'hff80_0000, 32'h7f80_0000, OpAdd, 1'b1, fas_pkg::QuietNan},
		'{32'h7fff_ffff, 32'h0000_0000, OpSub, 1'b1, fas_pkg::QuietNan},
		'{32'hffff_ffff, 32'hffff_ffff, OpAdd, 1'b1, fas_pkg::QuietNan},
		'{32'h007f_ffff, 32'h8000_0001, OpAdd, 1'b1, 32'h0000_0000},
		'{32'h0000_0001, 32'h3f80_0000, OpAdd, 1'b1, 32'h3f80_0000},
		'{32'h7f7f_ffff, 32'h7f7f_ffff, OpAdd, 1'b1, 32'h7f80_0000},
		'{32'hff7f_ffff, 32'h7f7f_ffff, OpSub, 1'b1, 32'hff80_0000},
		'{32'h7f00_0000, 32'h7f00_0000, OpAdd, 1'b1, 32'h7f80_0000},
		'{32'h8080_0001, 32'h8080_0000, OpSub, 1'b1, 32'h8000_0000},
		'{32'h3f80_0000, 32'h3f80_0000, OpAdd, 1'b1, 32'h4000_0000},
		'{32'h3f80_0000, 32'h3f80_0000, OpSub, 1'b1, 32'h0000_0000},
		'{32'h4040_0000, 32'h3f80_0000, OpSub, 1'b1, 32'h4000_0000},
		'{32'h3f80_0000, 32'h0f80_0000, OpAdd, 1'b1, 32'h3f80_0000},
		'{32'h4f80_0000, 32'h3f80_0000, OpAdd, 1'b0, 32'h0},
		'{32'h4f00_0000, 32'hbf80_0000, OpAdd, 1'b0, 32'h0},
		'{32'h3f80_0000, 32'hbf7f_ffff, OpAdd, 1'b0, 32'h0},
		'{32'h0080_0000, 32'h8080_0000, OpSub, 1'b0, 32'h0}
	};

	float32_add_subtract_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.mode      (mode),
		.done      (done),
		.result    (result)
	);

	always #1 clk = ~clk;

	// truncating single-precision add/sub, denormals flushed, no NaN payloads
	function automatic logic [31:0] fp_addsub(input logic [31:0] a, input logic [31:0] b,
			input logic op);
		logic        sgn_a;
		logic        sgn_b;
		logic        sgn_r;
		int          exp_a;
		int          exp_b;
		int          exp_r;
		int          gap;
		logic [24:0] sig_a;
		logic [24:0] sig_b;
		logic [24:0] mag;
		sgn_a = a[31];
		sgn_b = b[31] ^ (op == OpSub);
		exp_a = a[30:23];
		exp_b = b[30:23];
		if (a[30:23] == fas_pkg::ExpMax || b[30:23] == fas_pkg::ExpMax) begin
			return fas_pkg::QuietNan;
		end
		sig_a = (exp_a != 0) ? {2'b01, a[22:0]} : '0;
		sig_b = (exp_b != 0) ? {2'b01, b[22:0]} : '0;
		if (exp_a >= exp_b) begin
			exp_r = exp_a;
			gap   = exp_a - exp_b;
			sig_b = (gap > 31) ? '0 : sig_b >> gap;
		end else begin
			exp_r = exp_b;
			gap   = exp_b - exp_a;
			sig_a = (gap > 31) ? '0 : sig_a >> gap;
		end
		if (sgn_a == sgn_b) begin
			mag   = sig_a + sig_b;
			sgn_r = sgn_a;
		end else if (sig_a >= sig_b) begin
			mag   = sig_a - sig_b;
			sgn_r = sgn_a;
		end else begin
			mag   = sig_b - sig_a;
			sgn_r = sgn_b;
		end
		if (mag == '0) begin
			return 32'h0000_0000;
		end
		if (mag[24]) begin
			mag   = mag >> 1;
			exp_r = exp_r + 1;
		end else begin
			for (int i = 0; i < 24 && !mag[23]; i++) begin
				mag   = mag << 1;
				exp_r = exp_r - 1;
			end
		end
		if (exp_r >= 255) begin
			return {sgn_r, fas_pkg::ExpMax, 23'h0};
		end
		if (exp_r <= 0) begin
			return {sgn_r, 31'h0};
		end
		return {sgn_r, 8'(exp_r), mag[22:0]};
	endfunction

	// exponent mix weighted toward the special encodings and the range ends
	function automatic logic [7:0] pick_exp();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			return 8'h00;
		end
		if (r < 14) begin
			return fas_pkg::ExpMax;
		end
		if (r < 20) begin
			return $urandom_range(0, 1) ? 8'hfe : 8'h01;
		end
		return 8'($urandom_range(1, 254));
	endfunction

	task automatic issue_op(input logic [31:0] a, input logic [31:0] b, input logic op,
			input logic [31:0] want, input bit calm);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 14) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start     <= 1'b1;
		operand_a <= a;
		operand_b <= b;
		mode      <= op;
		want_now  <= want;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		ops_sent++;
	endtask

	task automatic drain_sums();
		@(negedge clk);
		start <= 1'b0;
		while (pending_sums.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// scoreboard and watchdog; results come out in issue order
	always @(posedge clk) begin
		fp_sum_t head;
		if (done) begin
			if (pending_sums.size() == 0) begin
				$error("result: unexpected beat %08h", result);
				fail_cnt++;
			end else begin
				head = pending_sums.pop_front();
				if (result !== head.want) begin
					$error("result: expected %08h, got %08h (a=%08h b=%08h mode=%0b)",
						head.want, result, head.a, head.b, head.op);
					fail_cnt++;
				end
			end
			sums_seen++;
			if (result == fas_pkg::QuietNan) nan_seen++;
			if (result[30:0] == '0) zero_seen++;
			if (result[30:0] == {fas_pkg::ExpMax, 23'h0}) inf_seen++;
		end
		if (start && !busy) begin
			pending_sums.push_back('{operand_a, operand_b, mode, want_now});
		end
		if (done || (start && !busy)) begin
			stall_cyc = 0;
		end else begin
			stall_cyc++;
		end
		if (stall_cyc >= StallLimit) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		logic [31:0] a;
		logic [31:0] b;
		logic        op;
		int          kind;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (fp_rows[i]) begin
			issue_op(fp_rows[i].a, fp_rows[i].b, fp_rows[i].op,
				fp_rows[i].known ? fp_rows[i].want
					: fp_addsub(fp_rows[i].a, fp_rows[i].b, fp_rows[i].op),
				1'b0);
		end
		drain_sums();

		for (int i = 0; i < NumRandom; i++) begin
			a    = $urandom;
			b    = $urandom;
			op   = 1'($urandom_range(0, 1));
			kind = $urandom_range(0, 99);
			if (kind >= 10) begin
				a[30:23] = pick_exp();
				b[30:23] = pick_exp();
			end
			if (kind >= 45 && kind < 80) begin
				b[30:23] = a[30:23] + 8'($urandom_range(0, 6)) - 8'd3;
			end else if (kind >= 80 && kind < 92) begin
				// alignment shift around the 24- and 31-bit limits
				b[30:23] = a[30:23] - 8'($urandom_range(20, 40));
			end else if (kind >= 92) begin
				// near-cancellation: opposite effective signs, close magnitudes
				b     = a ^ 32'($urandom_range(0, 15));
				b[31] = a[31] ^ ~op;
			end
			if ($urandom_range(0, 1)) begin
				{a, b} = {b, a};
			end
			issue_op(a, b, op, fp_addsub(a, b, op), i >= 400 && i < 700);
			if (i == 900) begin
				drain_sums();
			end
		end

		drain_sums();
		repeat (SettleCyc) @(posedge clk);

		$display("Issued %0d add/sub beats (%0d table rows), compared %0d results.",
			ops_sent, NumRows, sums_seen);
		$display("Result mix: %0d quiet NaN, %0d signed zero, %0d infinity.",
			nan_seen, zero_seen, inf_seen);
		if (fail_cnt == 0 && pending_sums.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

[files.f]
sv/fas_pkg.sv
sv/fas_front.sv
sv/fas_queue.sv
sv/fas_back.sv
sv/float32_add_subtract_core.sv
dv/tb_top.sv
